>>> hdl/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/fcpa_pkg.sv
// Package for the chunk pool allocator: codes, defaults and widths.
package fcpa_pkg;

   localparam int unsigned MAX_CHUNKS_DEF = 1024;

   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned CHUNK_W = 16;
   localparam int unsigned COUNT_W = 11;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [ADDR_W-1:0]  BASE_ADDR_RST    = '0;
   localparam logic [ADDR_W-1:0]  REGION_BYTES_RST = '0;
   localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RST  = 16'd16;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ADDR    = 2'd0,
      CSR_REGION_BYTES = 2'd1,
      CSR_CHUNK_BYTES  = 2'd2
   } csr_type;

endpackage

>>> hdl/fcpa_if.sv
// Valid/ready channel interfaces for request and response words.
interface fcpa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] address;

   modport source (output valid, output opcode, output address, input ready);
   modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface fcpa_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [31:0] chunk_addr;
   logic [10:0] in_use_count;
   logic        exhausted;

   modport source (output valid, output ok, output chunk_addr, output in_use_count,
                   output exhausted, input ready);
   modport sink   (input valid, input ok, input chunk_addr, input in_use_count,
                   input exhausted, output ready);
endinterface

>>> hdl/fixed_chunk_pool_allocator.sv
// Fixed-size chunk pool allocator: LIFO free list plus fresh-chunk counter.
//
// One request word is taken at a time; ready is high only while idle. An
// acquire passes from acceptance to a valid response through the free-list
// RAM read, one index-by-chunk-size multiply and one base add. A release or
// clear runs the shared restoring divider, which retires one quotient bit per
// cycle, giving offset / chunk_bytes and the remainder for a release and
// region_bytes / chunk_bytes for the capacity on a clear. A nop, an acquire
// with no chunk left or a release that fails the range check goes straight to
// the output register. Each response waits in the output register until
// taken. The free list lives in a MAX_CHUNKS-entry RAM that needs no clearing
// after reset.
module fixed_chunk_pool_allocator #(
   parameter int unsigned MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   fcpa_req_if.sink                       req_if,
   fcpa_rsp_if.source                     rsp_if,
   input  logic                           csr_wr_en,
   input  logic [fcpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fcpa_pkg::ADDR_W-1:0]    csr_wr_data
);

   localparam int unsigned IW = $clog2(MAX_CHUNKS);
   localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
   localparam int unsigned PW = IW + fcpa_pkg::CHUNK_W;
   localparam int unsigned LW = IW + 1;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHUNKS);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIV  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_ADDR = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   fcpa_pkg::op_type op_ff, op_in;
   logic [31:0]     base_ff, base_in;
   logic [31:0]     region_ff, region_in;
   logic [15:0]     chunk_ff, chunk_in;
   logic [CW-1:0]   capacity_ff, capacity_in;
   logic [CW-1:0]   next_fresh_ff, next_fresh_in;
   logic [IW-1:0]   head_ff, head_in;
   logic            head_valid_ff, head_valid_in;
   logic [CW-1:0]   in_use_ff, in_use_in;
   logic            pop_ff, pop_in;
   logic [IW-1:0]   mul_idx_ff, mul_idx_in;
   logic [PW-1:0]   prod_ff, prod_in;
   logic [15:0]     rem_ff, rem_in;
   logic [31:0]     quot_ff, quot_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            res_ok_ff, res_ok_in;
   logic [31:0]     res_addr_ff, res_addr_in;

   logic [32:0]     region_end;
   logic            in_range;
   logic [31:0]     offset;
   logic [16:0]     trial;
   logic [16:0]     diff;
   logic            ge;
   logic            quot_hi_zero;
   logic            idx_ok;
   logic [CW-1:0]   in_use_up;
   logic            ram_wr_en;
   logic [LW-1:0]   ram_wr_data;
   logic [LW-1:0]   ram_rd_data;
   logic [CW+10:0]  count_wide;

   fcpa_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_CHUNKS)
   ) u_links (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (quot_ff[IW-1:0]),
      .wr_data (ram_wr_data),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign region_end   = {1'b0, base_ff} + {1'b0, region_ff};
   assign in_range     = (req_if.address != '0) && (region_ff != '0) && (chunk_ff != '0) &&
                         (req_if.address >= base_ff) && ({1'b0, req_if.address} < region_end);
   assign offset       = req_if.address - base_ff;
   assign trial        = {rem_ff, quot_ff[31]};
   assign diff         = trial - {1'b0, chunk_ff};
   assign ge           = trial >= {1'b0, chunk_ff};
   assign quot_hi_zero = (quot_ff[31:CW] == '0);
   assign idx_ok       = (rem_ff == '0) && quot_hi_zero && (quot_ff[CW-1:0] < capacity_ff);
   assign in_use_up    = (in_use_ff < MAX_CNT) ? in_use_ff + 1'b1 : in_use_ff;
   assign ram_wr_data  = {head_valid_ff, head_ff};
   assign ram_wr_en    = (state_ff == ST_FIN) && (op_ff == fcpa_pkg::OP_RELEASE) && idx_ok;
   assign count_wide   = {11'd0, in_use_ff};

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = (state_ff == ST_OUT);
   assign rsp_if.ok           = res_ok_ff;
   assign rsp_if.chunk_addr   = res_addr_ff;
   assign rsp_if.in_use_count = count_wide[10:0];
   assign rsp_if.exhausted    = !head_valid_ff && (next_fresh_ff == capacity_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      base_in       = base_ff;
      region_in     = region_ff;
      chunk_in      = chunk_ff;
      capacity_in   = capacity_ff;
      next_fresh_in = next_fresh_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      in_use_in     = in_use_ff;
      pop_in        = pop_ff;
      mul_idx_in    = mul_idx_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      cnt_in        = cnt_ff;
      res_ok_in     = res_ok_ff;
      res_addr_in   = res_addr_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            fcpa_pkg::CSR_BASE_ADDR:    base_in   = csr_wr_data;
            fcpa_pkg::CSR_REGION_BYTES: region_in = csr_wr_data;
            fcpa_pkg::CSR_CHUNK_BYTES:  chunk_in  = csr_wr_data[15:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in       = fcpa_pkg::op_type'(req_if.opcode);
               res_ok_in   = 1'b0;
               res_addr_in = '0;
               unique case (fcpa_pkg::op_type'(req_if.opcode))
                  fcpa_pkg::OP_ACQUIRE: begin
                     if (head_valid_ff) begin
                        pop_in     = 1'b1;
                        mul_idx_in = head_ff;
                        in_use_in  = in_use_up;
                        state_in   = ST_MUL;
                     end else if (next_fresh_ff < capacity_ff) begin
                        pop_in        = 1'b0;
                        mul_idx_in    = next_fresh_ff[IW-1:0];
                        next_fresh_in = next_fresh_ff + 1'b1;
                        in_use_in     = in_use_up;
                        state_in      = ST_MUL;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  fcpa_pkg::OP_RELEASE: begin
                     if (in_range) begin
                        rem_in   = '0;
                        quot_in  = offset;
                        cnt_in   = 5'd31;
                        state_in = ST_DIV;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  fcpa_pkg::OP_CLEAR: begin
                     rem_in   = '0;
                     quot_in  = region_ff;
                     cnt_in   = 5'd31;
                     state_in = ST_DIV;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[15:0] : trial[15:0];
            quot_in = {quot_ff[30:0], ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_MUL: begin
            prod_in = PW'(mul_idx_ff) * PW'(chunk_ff);
            if (pop_ff) begin
               head_in       = ram_rd_data[IW-1:0];
               head_valid_in = ram_rd_data[IW];
            end
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            res_addr_in = base_ff + 32'(prod_ff);
            res_ok_in   = 1'b1;
            state_in    = ST_OUT;
         end
         ST_FIN: begin
            if (op_ff == fcpa_pkg::OP_CLEAR) begin
               if (chunk_ff == '0) begin
                  capacity_in = '0;
               end else if (!quot_hi_zero || (quot_ff[CW-1:0] > MAX_CNT)) begin
                  capacity_in = MAX_CNT;
               end else begin
                  capacity_in = quot_ff[CW-1:0];
               end
               next_fresh_in = '0;
               head_in       = '0;
               head_valid_in = 1'b0;
               in_use_in     = '0;
               res_ok_in     = 1'b1;
            end else if (idx_ok) begin
               head_in       = quot_ff[IW-1:0];
               head_valid_in = 1'b1;
               if (in_use_ff != '0) begin
                  in_use_in = in_use_ff - 1'b1;
               end
               res_ok_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= fcpa_pkg::OP_NOP;
         base_ff       <= fcpa_pkg::BASE_ADDR_RST;
         region_ff     <= fcpa_pkg::REGION_BYTES_RST;
         chunk_ff      <= fcpa_pkg::CHUNK_BYTES_RST;
         capacity_ff   <= '0;
         next_fresh_ff <= '0;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         in_use_ff     <= '0;
         pop_ff        <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         base_ff       <= base_in;
         region_ff     <= region_in;
         chunk_ff      <= chunk_in;
         capacity_ff   <= capacity_in;
         next_fresh_ff <= next_fresh_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         in_use_ff     <= in_use_in;
         pop_ff        <= pop_in;
         cnt_ff        <= cnt_in;
      end
      mul_idx_ff  <= mul_idx_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      res_ok_ff   <= res_ok_in;
      res_addr_ff <= res_addr_in;
   end

endmodule

>>> hdl/fcpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fcpa_checker.sv
// Port-level checker for the chunk pool allocator, bound to the top level.
`include "assert_macros.svh"

module fcpa_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [31:0] rsp_chunk_addr,
   input logic [10:0] rsp_in_use_count
);

   logic [1:0] last_op_ff, last_op_in;

   assign last_op_in = (req_valid && req_ready) ? req_opcode : last_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_op_ff <= fcpa_pkg::OP_NOP;
      end else begin
         last_op_ff <= last_op_in;
      end
   end

   `FCPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response word dropped while stalled")
   `FCPA_ASSERT_NOW(a_one_at_a_time, clock, reset, rsp_valid, !req_ready, "request taken while a response is pending")
   `FCPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after an accepted word")
   `FCPA_ASSERT_NOW(a_fail_zero_addr, clock, reset, rsp_valid && !rsp_ok, rsp_chunk_addr == 32'd0, "failed response carries an address")
   `FCPA_ASSERT_NOW(a_clear_result, clock, reset, rsp_valid && (last_op_ff == fcpa_pkg::OP_CLEAR), rsp_ok && (rsp_in_use_count == 11'd0) && (rsp_chunk_addr == 32'd0), "clear response malformed")

endmodule

bind fixed_chunk_pool_allocator fcpa_port_checker u_fcpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .req_opcode       (req_if.opcode),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_ok           (rsp_if.ok),
   .rsp_chunk_addr   (rsp_if.chunk_addr),
   .rsp_in_use_count (rsp_if.in_use_count)
);

>>> tb/fcpa_checker.sv
`timescale 1ns / 100ps
// Pool checker: mirrors the allocator state from observed words and compares responses.
module fcpa_checker
   import fcpa_pkg::*;
#(
   parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   fcpa_req_if                  req_mon,
   fcpa_rsp_if                  rsp_mon,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wr_data,
   output int                   miscompares,
   output int                   owed_count
);

   typedef struct packed {
      logic               ok;
      logic [ADDR_W-1:0]  chunk_addr;
      logic [COUNT_W-1:0] in_use_count;
      logic               exhausted;
   } pool_rsp_t;

   logic [ADDR_W-1:0]  cfg_base;
   logic [ADDR_W-1:0]  cfg_region;
   logic [CHUNK_W-1:0] cfg_chunk;

   int unsigned        capacity;
   int unsigned        next_fresh;
   int unsigned        in_use;
   logic [COUNT_W-1:0] free_head;
   logic               head_valid;
   logic [COUNT_W-1:0] link_next [MAX_CHUNKS];
   logic               link_valid [MAX_CHUNKS];

   pool_rsp_t owed_rsp [$];
   pool_rsp_t want;
   int        errs = 0;

   function automatic void reload_pool();
      capacity = 0;
      if (cfg_chunk != 0) begin
         capacity = cfg_region / cfg_chunk;
         if (capacity > MAX_CHUNKS) capacity = MAX_CHUNKS;
      end
      next_fresh = 0;
      free_head  = '0;
      head_valid = 1'b0;
      in_use     = 0;
   endfunction

   function automatic pool_rsp_t pool_op(op_type op, logic [ADDR_W-1:0] addr);
      pool_rsp_t         r;
      logic [ADDR_W:0]   region_end;
      logic [ADDR_W-1:0] offset;
      logic [ADDR_W-1:0] idx;
      logic [ADDR_W-1:0] chunk32;
      r = '0;
      chunk32 = {{(ADDR_W-CHUNK_W){1'b0}}, cfg_chunk};
      case (op)
         OP_ACQUIRE: begin
            if (head_valid) begin
               idx = free_head % MAX_CHUNKS;
               r.chunk_addr = cfg_base + idx * chunk32;
               free_head  = link_next[idx];
               head_valid = link_valid[idx];
               if (in_use < MAX_CHUNKS) in_use++;
               r.ok = 1'b1;
            end else if (next_fresh < capacity) begin
               idx = next_fresh;
               r.chunk_addr = cfg_base + idx * chunk32;
               next_fresh++;
               if (in_use < MAX_CHUNKS) in_use++;
               r.ok = 1'b1;
            end
         end
         OP_RELEASE: begin
            region_end = {1'b0, cfg_base} + {1'b0, cfg_region};
            if (addr != 0 && cfg_region != 0 && cfg_chunk != 0 &&
                addr >= cfg_base && {1'b0, addr} < region_end) begin
               offset = addr - cfg_base;
               if (offset % chunk32 == 0) begin
                  idx = offset / chunk32;
                  if (idx < capacity && idx < MAX_CHUNKS) begin
                     link_next[idx]  = free_head;
                     link_valid[idx] = head_valid;
                     free_head  = idx[COUNT_W-1:0];
                     head_valid = 1'b1;
                     if (in_use > 0) in_use--;
                     r.ok = 1'b1;
                  end
               end
            end
         end
         OP_CLEAR: begin
            reload_pool();
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.in_use_count = in_use[COUNT_W-1:0];
      r.exhausted    = !head_valid && (next_fresh == capacity);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_base   = BASE_ADDR_RST;
         cfg_region = REGION_BYTES_RST;
         cfg_chunk  = CHUNK_BYTES_RST;
         reload_pool();
         owed_rsp.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_type'(csr_index))
               CSR_BASE_ADDR:    cfg_base   = csr_wr_data;
               CSR_REGION_BYTES: cfg_region = csr_wr_data;
               CSR_CHUNK_BYTES:  cfg_chunk  = csr_wr_data[CHUNK_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            owed_rsp.push_back(pool_op(op_type'(req_mon.opcode), req_mon.address));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_rsp.size() == 0) begin
               $error("response word with no request outstanding");
               errs++;
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_mon.ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_mon.ok);
                  errs++;
               end
               if (rsp_mon.chunk_addr !== want.chunk_addr) begin
                  $error("chunk_addr: expected %h, got %h", want.chunk_addr,
                         rsp_mon.chunk_addr);
                  errs++;
               end
               if (rsp_mon.in_use_count !== want.in_use_count) begin
                  $error("in_use_count: expected %0d, got %0d", want.in_use_count,
                         rsp_mon.in_use_count);
                  errs++;
               end
               if (rsp_mon.exhausted !== want.exhausted) begin
                  $error("exhausted: expected %0d, got %0d", want.exhausted,
                         rsp_mon.exhausted);
                  errs++;
               end
            end
         end
      end
      owed_count  <= owed_rsp.size();
      miscompares <= errs;
   end

endmodule

>>> tb/fixed_chunk_pool_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, register setup, request stimulus and the verdict.
module fixed_chunk_pool_allocator_tb;
   import fcpa_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ADDR_W-1:0]    csr_wr_data;

   int          miscompares;
   int          owed_count;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   logic [ADDR_W-1:0]  pool_base;
   logic [ADDR_W-1:0]  pool_region;
   logic [CHUNK_W-1:0] pool_chunk;
   int unsigned        pool_slots;

   fcpa_req_if req();
   fcpa_rsp_if rsp();

   fixed_chunk_pool_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req),
      .rsp_if      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   fcpa_checker pool_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req),
      .rsp_mon     (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .miscompares (miscompares),
      .owed_count  (owed_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(op_type op, logic [ADDR_W-1:0] addr);
      req.valid   <= 1'b1;
      req.opcode  <= op;
      req.address <= addr;
      do @(posedge clock); while (!req.ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // wait until every response word has come back
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
   endtask

   task automatic set_pool(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] region,
                           logic [CHUNK_W-1:0] chunk);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_BASE_ADDR;
      csr_wr_data <= base;
      @(posedge clock);
      csr_index   <= CSR_REGION_BYTES;
      csr_wr_data <= region;
      @(posedge clock);
      csr_index   <= CSR_CHUNK_BYTES;
      csr_wr_data <= {{(ADDR_W-CHUNK_W){1'b0}}, chunk};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pool_base   = base;
      pool_region = region;
      pool_chunk  = chunk;
      pool_slots  = region / chunk;
      if (pool_slots > MAX_CHUNKS_DEF) pool_slots = MAX_CHUNKS_DEF;
   endtask

   initial begin
      int unsigned        pick;
      int unsigned        seg_len;
      logic [ADDR_W-1:0]  a;
      logic [ADDR_W-1:0]  b;
      logic [CHUNK_W-1:0] c;
      longint unsigned    region_l;
      longint unsigned    room;

      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_BASE_ADDR;
      csr_wr_data <= '0;
      req.valid   <= 1'b0;
      req.opcode  <= OP_NOP;
      req.address <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // pool not built yet
      send_word(OP_ACQUIRE, $urandom);

      // three chunks plus a partial tail
      set_pool(32'h0000_0100, 32'd52, 16'd16);
      send_word(OP_CLEAR, $urandom);
      repeat (4) send_word(OP_ACQUIRE, $urandom);
      send_word(OP_RELEASE, 32'h0000_0130);
      send_word(OP_RELEASE, 32'h0000_0108);
      send_word(OP_RELEASE, 32'h0000_0134);
      send_word(OP_RELEASE, 32'h0000_0110);
      send_word(OP_RELEASE, 32'h0000_0110);
      send_word(OP_RELEASE, 32'h0000_0100);
      send_word(OP_RELEASE, 32'h0000_0120);
      send_word(OP_ACQUIRE, $urandom);
      send_word(OP_ACQUIRE, $urandom);
      send_word(OP_NOP, $urandom);

      // whole address space, clamped capacity
      set_pool(32'h0000_0000, 32'hFFFF_FFFF, 16'd1);
      send_word(OP_CLEAR, $urandom);
      send_word(OP_ACQUIRE, $urandom);
      send_word(OP_RELEASE, 32'h0000_0000);
      send_word(OP_RELEASE, 32'h0000_0400);

      // region ends exactly at the top of the address space
      set_pool(32'hFFFF_0000, 32'h0001_0000, 16'hFFFF);
      send_word(OP_CLEAR, $urandom);
      send_word(OP_ACQUIRE, $urandom);
      send_word(OP_RELEASE, 32'hFFFF_FFFF);

      set_pool(32'hFFFF_0000, 32'h0000_0000, 16'hFFFF);
      send_word(OP_CLEAR, $urandom);
      send_word(OP_RELEASE, 32'hFFFF_0000);

      // extra pushes with nothing in use, then the same chunk handed out again
      set_pool(32'h8000_0000, 32'h0010_0000, 16'd1024);
      send_word(OP_CLEAR, $urandom);
      repeat (3) send_word(OP_RELEASE, 32'h8000_1400);
      repeat (12) send_word(OP_ACQUIRE, $urandom);
      repeat (4) send_word(OP_RELEASE, pool_base + $urandom_range(0, 1023) * pool_chunk);

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 58; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 58; end
            default: begin send_idle_pct = 8; rsp_stall_pct <= 8; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            case ($urandom_range(9))
               0:       c = CHUNK_W'($urandom_range(1, 65535));
               1:       c = 16'hFFFF;
               2:       c = 16'd1;
               default: c = CHUNK_W'($urandom_range(1, 64));
            endcase
            pick = $urandom_range(19);
            if (pick == 0)
               region_l = 0;
            else if (pick < 4)
               region_l = $urandom_range(1, 32'hFFFF_FFFF);
            else if (pick < 7)
               region_l = longint'(c) * $urandom_range(1, 24);
            else
               region_l = longint'(c) * $urandom_range(1, 24) + $urandom_range(0, c - 1);
            room = 64'h1_0000_0000 - region_l;
            pick = $urandom_range(7);
            if (pick == 0)
               b = '0;
            else if (pick == 1 && region_l != 0)
               b = ADDR_W'(room);
            else if (region_l == 0)
               b = $urandom;
            else
               b = $urandom_range(0, ADDR_W'(room));
            set_pool(b, ADDR_W'(region_l), c);
            if ($urandom_range(9) != 0) send_word(OP_CLEAR, $urandom);
            seg_len = $urandom_range(50, 80);
            repeat (seg_len) begin
               pick = $urandom_range(99);
               if (pick < 42) begin
                  send_word(OP_ACQUIRE, $urandom);
               end else if (pick < 72) begin
                  if (pool_slots > 0)
                     a = pool_base + $urandom_range(0, pool_slots - 1) * pool_chunk;
                  else
                     a = $urandom;
                  send_word(OP_RELEASE, a);
               end else if (pick < 78) begin
                  send_word(OP_RELEASE, pool_base + pool_slots * pool_chunk);
               end else if (pick < 84) begin
                  if (pool_chunk > 1)
                     a = pool_base + $urandom_range(0, 31) * pool_chunk +
                         $urandom_range(1, pool_chunk - 1);
                  else
                     a = $urandom;
                  send_word(OP_RELEASE, a);
               end else if (pick < 88) begin
                  send_word(OP_RELEASE, pool_base - $urandom_range(1, 16));
               end else if (pick < 91) begin
                  send_word(OP_RELEASE, pool_base + pool_region + $urandom_range(0, 15));
               end else if (pick < 95) begin
                  send_word(OP_RELEASE, $urandom);
               end else if (pick < 97) begin
                  send_word(OP_RELEASE, '0);
               end else if (pick < 99) begin
                  send_word(OP_CLEAR, $urandom);
               end else begin
                  send_word(OP_NOP, $urandom);
               end
            end
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (miscompares == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
